// ===== hw/rtl/nfses_pkg.sv =====
package nfses_pkg;

  // Command codes carried on the input tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Register indexes on the config channel
  localparam logic [2:0] CFG_REGION_BASE = 3'd0;
  localparam logic [2:0] CFG_SECTOR_LOG2 = 3'd1;
  localparam logic [2:0] CFG_SECTOR_CNT  = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT_MS  = 3'd3;
  localparam logic [2:0] CFG_PERM_EN     = 3'd4;

  // Status codes on the result channel
  typedef logic [1:0] status_t;
  localparam status_t ST_BUSY    = 2'd0;
  localparam status_t ST_DONE    = 2'd1;
  localparam status_t ST_TIMEOUT = 2'd2;

  // Flash command words
  localparam logic [15:0] FL_RESET   = 16'h00F0;
  localparam logic [15:0] FL_UNLK1   = 16'h00AA;
  localparam logic [15:0] FL_UNLK2   = 16'h0055;
  localparam logic [15:0] FL_ERASE   = 16'h0080;
  localparam logic [15:0] FL_SECTOR  = 16'h0030;
  localparam logic [17:0] FL_ADDR1   = 18'h00555;
  localparam logic [17:0] FL_ADDR2   = 18'h002AA;

  typedef enum logic [1:0] {
    KIND_STATUS,   // status result only
    KIND_RESETS,   // reset writes, then status
    KIND_ERASE     // reset writes, unlock, sector erase, then status
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [10:0] sector;
    logic [17:0] erase_addr;
    logic        perm;
  } job_t;

  typedef struct packed {
    logic [17:0] addr;
    logic [15:0] data;
  } bus_wr_t;

  // Board address line swizzle
  function automatic logic [17:0] board_perm(input logic [17:0] a);
    board_perm = {a[17:9], a[6], a[0], a[2], a[3], a[7], a[8], a[5], a[1], a[4]};
  endfunction

  // Five-write unlock + erase-setup preamble
  function automatic bus_wr_t unlock_word(input logic [2:0] idx, input logic perm);
    bus_wr_t w;
    w = '0;
    case (idx)
      3'd0: begin w.addr = FL_ADDR1; w.data = FL_UNLK1; end
      3'd1: begin w.addr = FL_ADDR2; w.data = FL_UNLK2; end
      3'd2: begin w.addr = FL_ADDR1; w.data = FL_ERASE; end
      3'd3: begin w.addr = FL_ADDR1; w.data = FL_UNLK1; end
      3'd4: begin w.addr = FL_ADDR2; w.data = FL_UNLK2; end
      default: w = '0;
    endcase
    if (perm) begin
      w.addr = board_perm(w.addr);
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/nfses_emit.sv =====
module nfses_emit #(
  parameter int RESET_WRITES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  nfses_pkg::job_t    job,
  output logic               job_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata,  // bus_word_addr, bus_data, status, sector_index, pad
  output logic               out_tuser,  // write_valid
  output logic               out_tlast
);

  localparam int BeatW = $clog2(RESET_WRITES + 7);
  localparam logic [BeatW-1:0] BeatRst   = BeatW'(RESET_WRITES);
  localparam logic [BeatW-1:0] BeatErase = BeatW'(RESET_WRITES + 5);
  localparam logic [BeatW-1:0] BeatEnd   = BeatW'(RESET_WRITES + 6);

  logic              job_valid_r;
  nfses_pkg::job_t   job_r;
  logic [BeatW-1:0]  beat_r;

  logic              out_valid_r;
  logic [17:0]       out_addr_r;
  logic [15:0]       out_data_r;
  nfses_pkg::status_t out_status_r;
  logic [10:0]       out_sector_r;
  logic              out_wv_r;
  logic              out_last_r;

  logic              load;
  logic              is_final;
  logic              pop;
  logic              push;
  logic [BeatW-1:0]  final_beat;
  logic [2:0]        ulk_idx;
  nfses_pkg::bus_wr_t ulk;

  logic              wv_c;
  logic [17:0]       addr_c;
  logic [15:0]       data_c;
  nfses_pkg::status_t status_c;
  logic              last_c;

  always_comb begin
    case (job_r.kind)
      nfses_pkg::KIND_RESETS: final_beat = BeatRst;
      nfses_pkg::KIND_ERASE:  final_beat = BeatEnd;
      default:                final_beat = '0;
    endcase
  end

  assign is_final  = (beat_r == final_beat);
  assign load      = !out_valid_r || out_tready;
  assign pop       = job_valid_r && load && is_final;
  assign job_ready = !job_valid_r || pop;
  assign push      = job_valid && job_ready;

  assign ulk_idx = 3'(beat_r - BeatRst);
  assign ulk     = nfses_pkg::unlock_word(ulk_idx, job_r.perm);

  // One result per beat
  always_comb begin
    wv_c     = 1'b1;
    addr_c   = '0;
    data_c   = '0;
    status_c = nfses_pkg::ST_BUSY;
    last_c   = 1'b0;
    if (is_final) begin
      wv_c     = 1'b0;
      status_c = job_r.status;
      last_c   = 1'b1;
    end else if (beat_r < BeatRst) begin
      data_c = nfses_pkg::FL_RESET;
    end else if (beat_r == BeatErase) begin
      addr_c = job_r.erase_addr;
      data_c = nfses_pkg::FL_SECTOR;
    end else begin
      addr_c = ulk.addr;
      data_c = ulk.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) begin
        job_valid_r <= 1'b1;
        beat_r      <= '0;
      end else if (pop) begin
        job_valid_r <= 1'b0;
        beat_r      <= '0;
      end else if (job_valid_r && load) begin
        beat_r <= beat_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= job_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_r <= job;
    end
    if (load && job_valid_r) begin
      out_wv_r     <= wv_c;
      out_addr_r   <= addr_c;
      out_data_r   <= data_c;
      out_status_r <= status_c;
      out_sector_r <= job_r.sector;
      out_last_r   <= last_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sector_r, out_status_r, out_data_r, out_addr_r};
  assign out_tuser  = out_wv_r;
  assign out_tlast  = out_last_r;

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> !out_wv_r)
    else $error("last result is a bus write");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wv_r |-> out_status_r == nfses_pkg::ST_BUSY && !out_last_r)
    else $error("bus write carries status or last");

  a_beat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> beat_r <= final_beat)
    else $error("beat counter ran past the final beat");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && out_last_r)
    else $error("job retired without a last result");

endmodule

// ===== hw/rtl/nor_flash_sector_erase_sequencer.sv =====
// The first result of an item passes through the job register, then the output register.
// Throughput: one result per cycle while out_tready is high; an item yields 1,
//   RESET_WRITES+1 or RESET_WRITES+7 results (39 max at defaults), set by the single
//   result port.
// The next item is taken in the cycle its final result loads the output register.
// Reset (rst_n low, synchronous) clears sector index, busy flag, deadline, in-flight
//   results and restores the register defaults.
module nor_flash_sector_erase_sequencer #(
  parameter int MAX_SECTORS  = 1024,
  parameter int RESET_WRITES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // sector_blank, status_read_a, status_read_b, now_ms, pad
  input  logic        in_tuser,   // cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // bus_word_addr, bus_data, status, sector_index, pad
  output logic        out_tuser,  // write_valid
  output logic        out_tlast,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  localparam logic [16:0] MaxSec = 17'(MAX_SECTORS);

  // config registers
  logic [18:0] region_base_r;
  logic [4:0]  sector_log2_r;
  logic [10:0] sector_cnt_r;
  logic [15:0] timeout_ms_r;
  logic        perm_en_r;

  // sequencer state
  logic [10:0] cur_r, cur_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] deadline_r, deadline_nxt;

  // input fields
  logic        f_cmd;
  logic        f_blank;
  logic [15:0] f_sa;
  logic [15:0] f_sb;
  logic [31:0] f_now;

  logic        accept;
  logic        job_ready;
  nfses_pkg::job_t job_c;

  logic [16:0] count_c;
  logic [10:0] cur_bump;
  logic [18:0] sec_off;
  logic [18:0] erase_byte;

  assign f_cmd   = in_tuser;
  assign f_blank = in_tdata[0];
  assign f_sa    = in_tdata[16:1];
  assign f_sb    = in_tdata[32:17];
  assign f_now   = in_tdata[64:33];

  assign in_tready = job_ready;
  assign accept    = in_tvalid && job_ready;
  assign cfg_ready = 1'b1;

  // Effective sector count, clamped to the build limit
  assign count_c  = ({6'b0, sector_cnt_r} < MaxSec) ? {6'b0, sector_cnt_r} : MaxSec;
  assign cur_bump = (cur_r != 11'h7FF) ? cur_r + 11'd1 : cur_r;

  // Erase target; only bits up to 18 of the byte offset reach the word address
  assign sec_off    = 19'({8'b0, cur_r} << sector_log2_r);
  assign erase_byte = region_base_r + sec_off;

  // Decide this item's burst and the next state
  always_comb begin
    cur_nxt          = cur_r;
    busy_nxt         = busy_r;
    deadline_nxt     = deadline_r;
    job_c.kind       = nfses_pkg::KIND_STATUS;
    job_c.status     = nfses_pkg::ST_BUSY;
    job_c.erase_addr = erase_byte[18:1];
    job_c.perm       = perm_en_r;
    if (f_cmd == nfses_pkg::CMD_START) begin
      cur_nxt      = '0;
      busy_nxt     = 1'b0;
      deadline_nxt = '0;
    end else if (busy_r) begin
      if (f_sa == f_sb) begin
        // toggle bit settled: erase finished
        busy_nxt   = 1'b0;
        cur_nxt    = cur_bump;
        job_c.kind = nfses_pkg::KIND_RESETS;
      end else if (f_now > deadline_r) begin
        job_c.status = nfses_pkg::ST_TIMEOUT;
      end
    end else if ({6'b0, cur_r} >= count_c) begin
      job_c.status = nfses_pkg::ST_DONE;
    end else if (f_blank) begin
      cur_nxt = cur_bump;
    end else begin
      busy_nxt     = 1'b1;
      deadline_nxt = f_now + {16'b0, timeout_ms_r};
      job_c.kind   = nfses_pkg::KIND_ERASE;
    end
    job_c.sector = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      busy_r     <= 1'b0;
      deadline_r <= '0;
    end else if (accept) begin
      cur_r      <= cur_nxt;
      busy_r     <= busy_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      sector_log2_r <= 5'd16;
      sector_cnt_r  <= '0;
      timeout_ms_r  <= 16'd4000;
      perm_en_r     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        nfses_pkg::CFG_REGION_BASE: region_base_r <= cfg_data;
        nfses_pkg::CFG_SECTOR_LOG2: sector_log2_r <= cfg_data[4:0];
        nfses_pkg::CFG_SECTOR_CNT:  sector_cnt_r  <= cfg_data[10:0];
        nfses_pkg::CFG_TIMEOUT_MS:  timeout_ms_r  <= cfg_data[15:0];
        nfses_pkg::CFG_PERM_EN:     perm_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Burst generator and output register
  nfses_emit #(
    .RESET_WRITES(RESET_WRITES)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (in_tvalid),
    .job        (job_c),
    .job_ready  (job_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && f_cmd == nfses_pkg::CMD_START |=> !busy_r && cur_r == '0 && deadline_r == '0)
    else $error("start did not clear the run");

  a_busy_needs_erase: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(accept) && $past(job_c.kind) == nfses_pkg::KIND_ERASE)
    else $error("busy set without an erase burst");

  a_sector_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cur_r))
    else $error("sector index moved without a transaction");

endmodule

// ===== tb/sv/nor_flash_sector_erase_sequencer_test.sv =====
`timescale 1ns / 1ps

module nor_flash_sector_erase_sequencer_test;

  // Sector index cap and the number of 0xF0 writes that bracket every erase
  localparam int          SECTOR_CAP    = 1024;
  localparam int          FLUSH_WRITES  = 32;
  // Stimulus stops once this many items went in (directed + random)
  localparam int          ITEM_GOAL     = 220;
  // Past the register list; the block must ignore it
  localparam logic [2:0]  CFG_NO_REG    = 3'd7;
  // Unlock preamble, entry 0 goes out first
  localparam logic [4:0][17:0] UNLOCK_ADDR = {nfses_pkg::FL_ADDR2, nfses_pkg::FL_ADDR1,
                                              nfses_pkg::FL_ADDR1, nfses_pkg::FL_ADDR2,
                                              nfses_pkg::FL_ADDR1};
  localparam logic [4:0][15:0] UNLOCK_DATA = {nfses_pkg::FL_UNLK2, nfses_pkg::FL_UNLK1,
                                              nfses_pkg::FL_ERASE, nfses_pkg::FL_UNLK2,
                                              nfses_pkg::FL_UNLK1};

  // One input item
  typedef struct packed {
    logic        cmd;
    logic        blank;
    logic [15:0] rd_a;
    logic [15:0] rd_b;
    logic [31:0] now;
  } step_t;

  // One result transaction
  typedef struct packed {
    logic               write_valid;
    logic [17:0]        addr;
    logic [15:0]        data;
    nfses_pkg::status_t status;
    logic [10:0]        sector;
    logic               last;
  } flash_op_t;

  // Directed script row: either a register write or an item, with an optional
  // hand-typed single status result
  typedef struct packed {
    logic               is_cfg;
    logic [2:0]         idx;
    logic [18:0]        val;
    logic               cmd;
    logic               blank;
    logic [15:0]        rd_a;
    logic [15:0]        rd_b;
    logic [31:0]        now;
    logic               typed;
    nfses_pkg::status_t st;
    logic [10:0]        sec;
  } row_t;

  localparam int SCRIPT_LEN = 28;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // sector_blank, status_read_a, status_read_b, now_ms, pad
  logic        in_tuser   = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // bus_word_addr, bus_data, status, sector_index, pad
  logic        out_tuser;         // write_valid
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [18:0] cfg_data   = '0;

  // Register shadow, reset defaults
  logic [18:0] reg_base    = '0;
  logic [4:0]  reg_log2    = 5'd16;
  logic [10:0] reg_count   = '0;
  logic [15:0] reg_timeout = 16'd4000;
  logic        reg_perm    = 1'b1;

  // Sequencer state as the predictor sees it
  logic [10:0] trk_sector   = '0;
  logic        trk_busy     = 1'b0;
  logic [31:0] trk_deadline = '0;

  flash_op_t   pending_ops[$];   // bus writes / status words still owed by the block
  int          mismatches  = 0;
  int          items_sent  = 0;
  bit          calm        = 1'b0;  // no idling on either side
  bit          hold_pending = 1'b0; // asks the result side for one long hold-off
  bit          cfg_open    = 1'b0;  // cfg_valid left high after the last write
  logic [31:0] clock_ms    = '0;    // running millisecond clock for random steps

  // Directed part. Typed rows carry an obvious single status result; all
  // others are checked against the predictor.
  row_t script [SCRIPT_LEN] = '{
    // default registers: nothing to erase
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_START, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000,
      1'b1, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000,
      1'b1, nfses_pkg::ST_DONE, 11'd0},
    // extremes: top base, zero shift, count beyond cap, 1 ms timeout, no swizzle
    '{1'b1, nfses_pkg::CFG_REGION_BASE, 19'h7FFFF,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_SECTOR_LOG2, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_SECTOR_CNT, 19'd2047,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_TIMEOUT_MS, 19'd1,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_PERM_EN, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, CFG_NO_REG, 19'h7FFFF,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_START, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000,
      1'b1, nfses_pkg::ST_BUSY, 11'd0},
    // erase at top of time: deadline wraps to zero
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    // now equal to deadline is not late
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0000, 16'hFFFF, 32'h0000_0000,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    // one past: timed out, still busy
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0001, 16'h0000, 32'h0000_0001,
      1'b1, nfses_pkg::ST_TIMEOUT, 11'd0},
    // late but toggling stopped: finishes anyway
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b1, 16'hFFFF, 16'hFFFF, 32'h0000_0002,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    // blank sector skipped
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b1, 16'h0000, 16'h0000, 32'h0000_0003,
      1'b1, nfses_pkg::ST_BUSY, 11'd2},
    // erase address wraps past the top of the bus
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'hAAAA, 16'h5555, 32'h8000_0000,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h5555, 16'hAAAA, 32'h8000_0001,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h1234, 16'h1234, 32'h8000_0002,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    // largest legal sector, swizzle back on, one sector, longest timeout
    '{1'b1, nfses_pkg::CFG_SECTOR_LOG2, 19'd19,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_PERM_EN, 19'd1,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_SECTOR_CNT, 19'd1,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b1, nfses_pkg::CFG_TIMEOUT_MS, 19'd65535,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0, 16'h0, 32'h0,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_START, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000,
      1'b1, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0000, 16'h0040, 32'hFFFF_FFFE,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    // start while an erase is running drops it
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_START, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
      1'b1, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h00FF, 16'hFF00, 32'h0000_0000,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0000, 16'h0000, 32'h0000_0010,
      1'b0, nfses_pkg::ST_BUSY, 11'd0},
    // all sectors handled, blank flag no longer matters
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b0, 16'h0000, 16'h0000, 32'h0000_0011,
      1'b1, nfses_pkg::ST_DONE, 11'd1},
    '{1'b0, nfses_pkg::CFG_REGION_BASE, 19'd0,
      nfses_pkg::CMD_STEP, 1'b1, 16'h0000, 16'h0000, 32'h0000_0012,
      1'b1, nfses_pkg::ST_DONE, 11'd1}
  };

  nor_flash_sector_erase_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: the slowest legal run is well under a tenth of this
  initial begin
    #4_000_000;
    $display("nor_flash_sector_erase_sequencer verification failed");
    $finish;
  end

  //------------------------------------------------------------------
  // Predictor
  //------------------------------------------------------------------

  // Board wiring swaps address lines 0 and 2..8 on the unlock cycles
  function automatic logic [17:0] swizzle(input logic [17:0] a);
    logic [17:0] r;
    r    = a & 18'h3FE02;
    r[7] = a[0];
    r[6] = a[2];
    r[5] = a[3];
    r[0] = a[4];
    r[2] = a[5];
    r[8] = a[6];
    r[4] = a[7];
    r[3] = a[8];
    return r;
  endfunction

  function automatic void owe(input bit keep, input logic wv, input logic [17:0] addr,
                              input logic [15:0] data, input nfses_pkg::status_t st,
                              input logic last);
    flash_op_t op;
    op.write_valid = wv;
    op.addr        = addr;
    op.data        = data;
    op.status      = st;
    op.sector      = trk_sector;
    op.last        = last;
    if (keep) begin
      pending_ops.push_back(op);
    end
  endfunction

  function automatic void owe_flush(input bit keep);
    for (int k = 0; k < FLUSH_WRITES; k++) begin
      owe(keep, 1'b1, '0, nfses_pkg::FL_RESET, nfses_pkg::ST_BUSY, 1'b0);
    end
  endfunction

  function automatic void next_sector();
    if (trk_sector != 11'h7FF) begin
      trk_sector = trk_sector + 11'd1;
    end
  endfunction

  function automatic void apply_cfg(input logic [2:0] idx, input logic [18:0] val);
    case (idx)
      nfses_pkg::CFG_REGION_BASE: reg_base    = val;
      nfses_pkg::CFG_SECTOR_LOG2: reg_log2    = val[4:0];
      nfses_pkg::CFG_SECTOR_CNT:  reg_count   = val[10:0];
      nfses_pkg::CFG_TIMEOUT_MS:  reg_timeout = val[15:0];
      nfses_pkg::CFG_PERM_EN:     reg_perm    = val[0];
      default: ;
    endcase
  endfunction

  // Advances the tracked state by one item; keep=0 only updates state
  function automatic void erase_step(input step_t s, input bit keep);
    logic [10:0] span;
    logic [63:0] byte_off;
    logic [17:0] ua;
    span = (reg_count > 11'(SECTOR_CAP)) ? 11'(SECTOR_CAP) : reg_count;
    if (s.cmd == nfses_pkg::CMD_START) begin
      trk_sector   = '0;
      trk_busy     = 1'b0;
      trk_deadline = '0;
      owe(keep, 1'b0, '0, '0, nfses_pkg::ST_BUSY, 1'b1);
    end else if (trk_busy) begin
      // toggle bit polling
      if (s.rd_a == s.rd_b) begin
        trk_busy = 1'b0;
        next_sector();
        owe_flush(keep);
        owe(keep, 1'b0, '0, '0, nfses_pkg::ST_BUSY, 1'b1);
      end else if (s.now > trk_deadline) begin
        owe(keep, 1'b0, '0, '0, nfses_pkg::ST_TIMEOUT, 1'b1);
      end else begin
        owe(keep, 1'b0, '0, '0, nfses_pkg::ST_BUSY, 1'b1);
      end
    end else if (trk_sector >= span) begin
      owe(keep, 1'b0, '0, '0, nfses_pkg::ST_DONE, 1'b1);
    end else if (s.blank) begin
      next_sector();
      owe(keep, 1'b0, '0, '0, nfses_pkg::ST_BUSY, 1'b1);
    end else begin
      byte_off     = {45'b0, reg_base} + ({53'b0, trk_sector} << reg_log2);
      trk_busy     = 1'b1;
      trk_deadline = s.now + {16'b0, reg_timeout};
      owe_flush(keep);
      for (int k = 0; k < 5; k++) begin
        ua = reg_perm ? swizzle(UNLOCK_ADDR[k]) : UNLOCK_ADDR[k];
        owe(keep, 1'b1, ua, UNLOCK_DATA[k], nfses_pkg::ST_BUSY, 1'b0);
      end
      owe(keep, 1'b1, byte_off[18:1], nfses_pkg::FL_SECTOR, nfses_pkg::ST_BUSY, 1'b0);
      owe(keep, 1'b0, '0, '0, nfses_pkg::ST_BUSY, 1'b1);
    end
  endfunction

  //------------------------------------------------------------------
  // Result side: back-pressure and checking
  //------------------------------------------------------------------

  // Random stalls, plus one long hold-off on request so the block
  // backs up into its input
  initial begin : result_pacing
    int hold_left;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        for (hold_left = 200; hold_left > 0; hold_left--) begin
          @(posedge clk);
        end
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    flash_op_t seen;
    flash_op_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.write_valid = out_tuser;
      seen.addr        = out_tdata[17:0];
      seen.data        = out_tdata[33:18];
      seen.status      = out_tdata[35:34];
      seen.sector      = out_tdata[46:36];
      seen.last        = out_tlast;
      if (pending_ops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected: wv=%0d addr=%h data=%h st=%0d sec=%0d",
                   $realtime, seen.write_valid, seen.addr, seen.data, seen.status, seen.sector);
        end
      end else begin
        want = pending_ops.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected wv=%0d addr=%h data=%h st=%0d sec=%0d last=%0d",
                     $realtime, want.write_valid, want.addr, want.data, want.status,
                     want.sector, want.last);
            $display("%0t:   actual wv=%0d addr=%h data=%h st=%0d sec=%0d last=%0d",
                     $realtime, seen.write_valid, seen.addr, seen.data, seen.status,
                     seen.sector, seen.last);
          end
        end
      end
    end
  end

  //------------------------------------------------------------------
  // Input and config side
  //------------------------------------------------------------------

  // Stop offering and let every owed result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_valid stays high over back-to-back writes; the next item drops it
  task automatic cfg_write(input logic [2:0] idx, input logic [18:0] val);
    if (!cfg_open) begin
      settle();
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, val);
    cfg_open = 1'b1;
  endtask

  task automatic offer_step(input step_t s, input bit typed, input nfses_pkg::status_t st,
                            input logic [10:0] sec);
    flash_op_t op;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.cmd;
    in_tdata  <= {7'b0, s.now, s.rd_b, s.rd_a, s.blank};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transaction accepted at this edge
    if (typed) begin
      erase_step(s, 1'b0);
      op = '{1'b0, 18'd0, 16'd0, st, sec, 1'b1};
      pending_ops.push_back(op);
    end else begin
      erase_step(s, 1'b1);
    end
    items_sent++;
  endtask

  // Mostly well-formed polling: a few toggling reads, then equal ones,
  // with the clock drifting past the deadline now and then
  function automatic step_t roll_step();
    step_t s;
    s.cmd   = nfses_pkg::CMD_STEP;
    s.blank = ($urandom_range(0, 3) == 0);
    s.rd_a  = 16'($urandom);
    s.rd_b  = s.rd_a;
    clock_ms = clock_ms + 32'($urandom_range(0, (reg_timeout >> 1) + 1));
    s.now   = clock_ms;
    if (trk_busy) begin
      case ($urandom_range(0, 7))
        0, 1, 2: ;  // toggling stopped
        3: s.rd_b = s.rd_a ^ (16'h1 << $urandom_range(0, 15));
        4: begin
          s.rd_b = ~s.rd_a;
          s.now  = trk_deadline;
        end
        5: begin
          s.rd_b = ~s.rd_a;
          s.now  = trk_deadline + 32'd1;
        end
        default: s.rd_b = 16'($urandom);
      endcase
    end
    // noise
    if ($urandom_range(0, 24) == 0) begin
      s.cmd  = $urandom_range(0, 1) ? nfses_pkg::CMD_STEP : nfses_pkg::CMD_START;
      s.now  = $urandom;
      s.rd_b = 16'($urandom);
    end
    return s;
  endfunction

  task automatic roll_config(input bit loaded);
    logic [18:0] v;
    v = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 19'h7FFFF : 19'd0)
                                    : 19'($urandom);
    cfg_write(nfses_pkg::CFG_REGION_BASE, v);
    case ($urandom_range(0, 9))
      0:       v = 19'($urandom_range(20, 31));
      1:       v = 19'd0;
      default: v = 19'($urandom_range(1, 19));
    endcase
    cfg_write(nfses_pkg::CFG_SECTOR_LOG2, v);
    case ($urandom_range(0, 7))
      0:       v = 19'(SECTOR_CAP);
      1:       v = 19'($urandom_range(SECTOR_CAP + 1, 2047));
      default: v = 19'($urandom_range(0, 5));
    endcase
    if (loaded) begin
      v = 19'd4;
    end
    cfg_write(nfses_pkg::CFG_SECTOR_CNT, v);
    case ($urandom_range(0, 9))
      0:       v = 19'd1;
      1:       v = 19'd65535;
      2:       v = 19'd0;
      default: v = 19'($urandom_range(1, 9000));
    endcase
    cfg_write(nfses_pkg::CFG_TIMEOUT_MS, v);
    cfg_write(nfses_pkg::CFG_PERM_EN, 19'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(3'($urandom_range(5, 7)), 19'($urandom));
    end
  endtask

  initial begin : stimulus
    row_t  r;
    step_t s;
    int    n_steps;
    int    phase;
    int    guard;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed script
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      r = script[i];
      if (r.is_cfg) begin
        cfg_write(r.idx, r.val);
      end else begin
        s = '{r.cmd, r.blank, r.rd_a, r.rd_b, r.now};
        offer_step(s, r.typed, r.st, r.sec);
      end
    end

    // random runs: new registers, a start, then a burst of steps
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      roll_config(phase == 2);
      clock_ms = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FF00 : $urandom;
      if (items_sent >= ITEM_GOAL - 40) begin
        calm = 1'b1;
      end
      // long result-side hold-off while items keep coming
      if (phase == 2) begin
        hold_pending = 1'b1;
      end
      s = '{nfses_pkg::CMD_START, 1'b0, 16'h0, 16'h0, clock_ms};
      offer_step(s, 1'b0, nfses_pkg::ST_BUSY, '0);
      n_steps = $urandom_range(4, 24);
      for (int k = 0; k < n_steps && items_sent < ITEM_GOAL; k++) begin
        offer_step(roll_step(), 1'b0, nfses_pkg::ST_BUSY, '0);
      end
      phase++;
    end

    // drain
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_ops.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    if (mismatches == 0 && pending_ops.size() == 0) begin
      $display("nor_flash_sector_erase_sequencer verification clean");
    end else begin
      $display("nor_flash_sector_erase_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nfses_pkg.sv
hw/rtl/nfses_emit.sv
hw/rtl/nor_flash_sector_erase_sequencer.sv
tb/sv/nor_flash_sector_erase_sequencer_test.sv
